/* rtl/mbf_pkg.sv */
// ----------------------------------------------------------------------------
// Mipmap box filter chain: shared package
// Widths, register codes, reset values, status structs and the per-channel
// pair-sum and block-average functions used by the filter cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mbf_pkg;

   localparam int MAX_SIZE_LOG2_DEFAULT = 10;

   localparam int PIXEL_W   = 32;
   localparam int PAIR_W    = 36;
   localparam int LEVEL_W   = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_SIZE_LOG2   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_COUNT = 2'd1;

   localparam logic [CSR_DATA_W-1:0] SIZE_LOG2_RESET   = 4'd8;
   localparam logic [CSR_DATA_W-1:0] LEVEL_COUNT_RESET = 4'd0;

   // Per-cell status toward the top level.
   typedef struct packed {
      logic stop;   // transaction ends at this cell without a result
      logic cont;   // this cell will produce a result (read issued)
      logic prod;   // averaged pixel is valid this cycle
      logic busy;   // a result is still in flight inside the cell
   } cell_stat_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] mip_level;
      logic [PIXEL_W-1:0] mip_pixel;
      logic               last_of_run;
   } rsp_entry_type;

   // Four 9-bit channel sums of two pixels, channel k at bits 9k.
   function automatic logic [PAIR_W-1:0] pair_sum(input logic [PIXEL_W-1:0] a,
                                                  input logic [PIXEL_W-1:0] b);
      logic [PAIR_W-1:0] r;
      r = '0;
      for (int k = 0; k < 4; k++) begin
         r[9*k +: 9] = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
      end
      return r;
   endfunction

   // Adds two pair sums per channel and divides each total by four.
   function automatic logic [PIXEL_W-1:0] block_average(input logic [PAIR_W-1:0] top,
                                                        input logic [PAIR_W-1:0] bot);
      logic [PIXEL_W-1:0] r;
      logic [9:0]         s;
      r = '0;
      for (int k = 0; k < 4; k++) begin
         s = {1'b0, top[9*k +: 9]} + {1'b0, bot[9*k +: 9]};
         r[8*k +: 8] = s[9:2];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/mbf_if.sv */
// ----------------------------------------------------------------------------
// Mipmap box filter chain: channel interfaces
// Valid/ready channels for base pixels, mip results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbf_req_if;
   logic                         valid;
   logic                         ready;
   logic [mbf_pkg::PIXEL_W-1:0]  pixel_argb;

   modport source (output valid, output pixel_argb, input ready);
   modport sink   (input valid, input pixel_argb, output ready);
endinterface

interface mbf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mbf_pkg::LEVEL_W-1:0]  mip_level;
   logic [mbf_pkg::PIXEL_W-1:0]  mip_pixel;
   logic                         last_of_run;

   modport source (output valid, output mip_level, output mip_pixel,
                   output last_of_run, input ready);
   modport sink   (input valid, input mip_level, input mip_pixel,
                   input last_of_run, output ready);
endinterface

interface mbf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mbf_pkg::CSR_ADDR_W-1:0]  addr;
   logic [mbf_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* rtl/mbf_ram.sv */
// ----------------------------------------------------------------------------
// Mipmap box filter chain: generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mbf_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/mbf_cell.sv */
// ----------------------------------------------------------------------------
// Mipmap box filter chain: level cell
// Holds the position counters, the even-column pixel and the pair-sum line of
// one mip level, and hands each finished 2x2 average to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mbf_cell #(
   parameter int MAX_SIZE_LOG2 = mbf_pkg::MAX_SIZE_LOG2_DEFAULT,
   parameter int LEVEL         = 0
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             restart,
   input  wire logic                             enable,
   input  wire logic [mbf_pkg::CSR_DATA_W-1:0]   size_log2,
   input  wire logic                             in_valid,
   input  wire logic [mbf_pkg::PIXEL_W-1:0]      in_pixel,
   output mbf_pkg::cell_stat_type                stat,
   output logic      [mbf_pkg::PIXEL_W-1:0]      out_pixel
);

   localparam int CW     = MAX_SIZE_LOG2;
   localparam int DEPTH  = 2 ** (MAX_SIZE_LOG2 - 1 - LEVEL);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CW-1:0]                   col_ff, col_in, row_ff, row_in;
   logic [mbf_pkg::PIXEL_W-1:0]     even_ff;
   logic [mbf_pkg::PAIR_W-1:0]      ps_ff;
   logic                            st2_ff;
   logic                            out_valid_ff;
   logic [mbf_pkg::PIXEL_W-1:0]     out_pixel_ff;

   logic                            act;
   logic [mbf_pkg::CSR_DATA_W-1:0]  shamt;
   logic [CW:0]                     w;
   logic                            oob;
   logic [CW-1:0]                   col_c, row_c;
   logic [CW:0]                     col_inc, row_inc;
   logic                            wrap_col, wrap_row;
   logic [mbf_pkg::PAIR_W-1:0]      ps;
   logic                            wr_en, rd_en;
   logic [ADDR_W-1:0]               addr;
   logic [mbf_pkg::PAIR_W-1:0]      rd_data;

   always_comb begin
      act   = in_valid & enable;
      shamt = size_log2 - mbf_pkg::CSR_DATA_W'(LEVEL);
      w     = (CW+1)'(1) << shamt;
      oob   = ({1'b0, col_ff} >= w) || ({1'b0, row_ff} >= w);
      col_c = oob ? '0 : col_ff;
      row_c = oob ? '0 : row_ff;

      col_inc  = {1'b0, col_c} + (CW+1)'(1);
      row_inc  = {1'b0, row_c} + (CW+1)'(1);
      wrap_col = (col_inc == w);
      wrap_row = (row_inc == w);

      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (act) begin
         col_in = wrap_col ? '0 : col_inc[CW-1:0];
         row_in = row_c;
         if (wrap_col) begin
            row_in = wrap_row ? '0 : row_inc[CW-1:0];
         end
      end

      ps    = mbf_pkg::pair_sum(even_ff, in_pixel);
      wr_en = act & col_c[0] & ~row_c[0];
      rd_en = act & col_c[0] & row_c[0];
      addr  = ADDR_W'(col_c >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         st2_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         st2_ff       <= rd_en;
         out_valid_ff <= st2_ff;
      end
      if (act & ~col_c[0]) begin
         even_ff <= in_pixel;
      end
      if (rd_en) begin
         ps_ff <= ps;
      end
      if (st2_ff) begin
         out_pixel_ff <= mbf_pkg::block_average(rd_data, ps_ff);
      end
   end

   mbf_ram #(
      .WIDTH (mbf_pkg::PAIR_W),
      .DEPTH (DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (ps),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stat.stop = act & ~rd_en;
      stat.cont = rd_en;
      stat.prod = out_valid_ff;
      stat.busy = st2_ff | out_valid_ff;
   end

   assign out_pixel = out_pixel_ff;

endmodule

`default_nettype wire

/* rtl/mipmap_box_filter_chain_core.sv */
// ----------------------------------------------------------------------------
// Mipmap box filter chain: top level
// Generates up to level_count lower mip levels of a streamed ARGB8888 texture with a
// 2x2 truncating box filter, one level cell per mip level.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries base-level pixels in raster order; rsp_chan returns the
//   mip pixels each one completes, lowest level number first, with
//   last_of_run set on the final result of a transaction. csr_chan writes
//   size_log2 (address 0) and level_count (address 1); either write restarts
//   the texture at its first pixel. Write registers only while idle.
// Timing:
//   A transaction enters level cell 1 in the cycle it is accepted. A pixel
//   that completes a block at a level passes through that level's cell:
//   the pair-sum line RAM read (registered) and the pair sum are held, then
//   the average is registered and goes on to the next cell and the result
//   queue. A transaction occupies the chain until its last result is made.
//   Three of four base pixels cause none and never occupy the chain.
// Stalls and reset:
//   Results wait in a small queue; a new transaction is accepted once the
//   chain is empty and the queue has room for its worst case, so a stalled
//   receiver stops input once fewer entries are free than the level count.
//   Reset sets size_log2 to 8, level_count to 0 and clears all counters and
//   the queue; buffers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module mipmap_box_filter_chain_core #(
   parameter int MAX_SIZE_LOG2 = mbf_pkg::MAX_SIZE_LOG2_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mbf_req_if.sink    req_chan,
   mbf_rsp_if.source  rsp_chan,
   mbf_csr_if.sink    csr_chan
);

   localparam int QD    = MAX_SIZE_LOG2 + 1;
   localparam int PTR_W = $clog2(QD);
   localparam int CNT_W = $clog2(QD + 1);
   localparam int DW    = mbf_pkg::CSR_DATA_W;

   logic [DW-1:0]   size_log2_ff, size_log2_in;
   logic [DW-1:0]   level_count_ff, level_count_in;
   logic            restart;
   logic [DW-1:0]   size_eff, level_eff;
   logic [MAX_SIZE_LOG2-1:0] cell_en;

   logic            run_ff, run_in;
   logic            accept;
   logic            room_ok;

   mbf_pkg::cell_stat_type          stat [MAX_SIZE_LOG2];
   logic [mbf_pkg::PIXEL_W-1:0]     cell_pixel [MAX_SIZE_LOG2];
   logic [MAX_SIZE_LOG2-1:0]        busy_vec;

   logic                            stop_any, cont_any, prod_any;
   mbf_pkg::rsp_entry_type          push_entry;

   mbf_pkg::rsp_entry_type          q_ff [QD];
   logic [PTR_W-1:0]                wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                q_count_ff, q_count_in;
   logic                            pop;

   // Register writes.
   always_comb begin
      size_log2_in   = size_log2_ff;
      level_count_in = level_count_ff;
      restart        = 1'b0;
      if (csr_chan.valid) begin
         case (csr_chan.addr)
            mbf_pkg::CSR_SIZE_LOG2: begin
               size_log2_in = csr_chan.data;
               restart      = 1'b1;
            end
            mbf_pkg::CSR_LEVEL_COUNT: begin
               level_count_in = csr_chan.data;
               restart        = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   always_comb begin
      if (size_log2_ff == '0) begin
         size_eff = DW'(1);
      end else if (size_log2_ff > DW'(MAX_SIZE_LOG2)) begin
         size_eff = DW'(MAX_SIZE_LOG2);
      end else begin
         size_eff = size_log2_ff;
      end
      level_eff = (level_count_ff < size_eff) ? level_count_ff : size_eff;
      for (int i = 0; i < MAX_SIZE_LOG2; i++) begin
         cell_en[i] = (DW'(i) < level_eff);
      end
   end

   // The chain holds one transaction at a time.
   always_comb begin
      room_ok = (32'(q_count_ff) + 32'(level_eff)) <= QD;
      req_chan.ready = ~run_ff & room_ok;
      accept = req_chan.valid & req_chan.ready;
   end

   genvar g;
   generate
      for (g = 0; g < MAX_SIZE_LOG2; g++) begin : g_cell
         logic                        cin_valid;
         logic [mbf_pkg::PIXEL_W-1:0] cin_pixel;
         if (g == 0) begin : g_first
            assign cin_valid = accept;
            assign cin_pixel = req_chan.pixel_argb;
         end else begin : g_next
            assign cin_valid = stat[g-1].prod;
            assign cin_pixel = cell_pixel[g-1];
         end

         mbf_cell #(
            .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
            .LEVEL         (g)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .restart   (restart),
            .enable    (cell_en[g]),
            .size_log2 (size_eff),
            .in_valid  (cin_valid),
            .in_pixel  (cin_pixel),
            .stat      (stat[g]),
            .out_pixel (cell_pixel[g])
         );

         assign busy_vec[g] = stat[g].busy;
      end
   endgenerate

   // Only one cell is active; a result is the last of its run unless the
   // next cell starts another average in the same cycle.
   always_comb begin
      stop_any   = 1'b0;
      cont_any   = 1'b0;
      prod_any   = 1'b0;
      push_entry = '0;
      for (int i = 0; i < MAX_SIZE_LOG2; i++) begin
         stop_any = stop_any | stat[i].stop;
         cont_any = cont_any | stat[i].cont;
         prod_any = prod_any | stat[i].prod;
         if (stat[i].prod) begin
            push_entry.mip_level = mbf_pkg::LEVEL_W'(i + 1);
            push_entry.mip_pixel = cell_pixel[i];
         end
      end
      push_entry.last_of_run = ~cont_any;
      run_in = (run_ff | (accept & (level_eff != '0)))
               & ~(stop_any | (prod_any & ~cont_any));
   end

   // Result queue.
   always_comb begin
      pop       = rsp_chan.valid & rsp_chan.ready;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (prod_any) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QD - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QD - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      q_count_in = q_count_ff + CNT_W'(prod_any) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff   <= mbf_pkg::SIZE_LOG2_RESET;
         level_count_ff <= mbf_pkg::LEVEL_COUNT_RESET;
         run_ff         <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         q_count_ff     <= '0;
      end else begin
         size_log2_ff   <= size_log2_in;
         level_count_ff <= level_count_in;
         run_ff         <= run_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         q_count_ff     <= q_count_in;
      end
      if (prod_any) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_comb begin
      rsp_chan.valid       = (q_count_ff != '0);
      rsp_chan.mip_level   = q_ff[rd_ptr_ff].mip_level;
      rsp_chan.mip_pixel   = q_ff[rd_ptr_ff].mip_pixel;
      rsp_chan.last_of_run = q_ff[rd_ptr_ff].last_of_run;
   end

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= CNT_W'(QD))
      else $error("result queue count exceeds its depth");

   a_one_cell_busy: assert property (@(posedge clock) disable iff (reset)
      $onehot0(busy_vec))
      else $error("more than one level cell holds a transaction");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      prod_any |-> (q_count_ff < CNT_W'(QD)))
      else $error("result produced while the queue is full");

   a_idle_chain_empty: assert property (@(posedge clock) disable iff (reset)
      !run_ff |-> (busy_vec == '0))
      else $error("level cell busy while no transaction is running");
`endif

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mipmap box filter chain: testbench
// Streams base-level textures into the core and checks every mip pixel
// that comes back against an in-bench model of the 2x2 box-filter cascade.
// Covers reset defaults, size and level clamping, register restarts, the
// largest size and random textures under four sender/receiver idling mixes.
// ----------------------------------------------------------------------------

module tb_top;
   import mbf_pkg::*;

   localparam int MAX_LOG2       = MAX_SIZE_LOG2_DEFAULT;
   localparam int LINE_DEPTH     = (1 << MAX_LOG2) - 1;
   localparam int DRAIN_CYCLES   = 2 * MAX_LOG2 + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 75;

   // Address with no register behind it; a write must not restart the chain.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_ADDR = 2'd3;

   logic clock;
   logic reset;

   mbf_req_if req_chan ();
   mbf_rsp_if rsp_chan ();
   mbf_csr_if csr_chan ();

   mipmap_box_filter_chain_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Model state: registers, per-level position, left pixel of each pair and
   // the per-channel pair sums of the upper row of each block.
   logic [CSR_DATA_W-1:0] cur_size;
   logic [CSR_DATA_W-1:0] cur_levels;
   int unsigned           col_pos [MAX_LOG2+1];
   int unsigned           row_pos [MAX_LOG2+1];
   logic [PIXEL_W-1:0]    left_pixel [MAX_LOG2];
   logic [8:0]            upper_pair [LINE_DEPTH][4];

   rsp_entry_type pending_mips [$];

   int gap_pct;
   int stall_pct;
   int mismatch_count;
   int quiet_cycles;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int unsigned clamped_size(input logic [CSR_DATA_W-1:0] sz);
      if (sz < 1) return 1;
      if (32'(sz) > MAX_LOG2) return MAX_LOG2;
      return 32'(sz);
   endfunction

   function automatic int unsigned active_levels();
      int unsigned s;
      s = clamped_size(cur_size);
      return (32'(cur_levels) < s) ? 32'(cur_levels) : s;
   endfunction

   function automatic void restart_chain();
      for (int i = 0; i <= MAX_LOG2; i++) begin
         col_pos[i] = 0;
         row_pos[i] = 0;
      end
   endfunction

   // Runs one base pixel through the cascade and queues the mip pixels it
   // completes, lowest level first.
   function automatic void predict_mips(input logic [PIXEL_W-1:0] base);
      int unsigned   s, eff, w, col, row, idx, lvl, n_out;
      bit            chain_on, made;
      logic [PIXEL_W-1:0] pix, avg;
      logic [8:0]    bsum [4];
      logic [9:0]    total;
      rsp_entry_type ent;
      s        = clamped_size(cur_size);
      eff      = active_levels();
      pix      = base;
      avg      = '0;
      n_out    = 0;
      chain_on = 1'b1;
      for (lvl = 0; lvl < eff && chain_on; lvl++) begin
         w    = 1 << (s - lvl);
         col  = col_pos[lvl];
         row  = row_pos[lvl];
         made = 1'b0;
         if (col >= w || row >= w) begin
            col = 0;
            row = 0;
         end
         if (col % 2 == 0) begin
            left_pixel[lvl] = pix;
         end else begin
            for (int k = 0; k < 4; k++) begin
               bsum[k] = {1'b0, left_pixel[lvl][8*k +: 8]} + {1'b0, pix[8*k +: 8]};
            end
            idx = (1 << s) - w + col / 2;
            if (idx < LINE_DEPTH) begin
               if (row % 2 == 0) begin
                  for (int k = 0; k < 4; k++) upper_pair[idx][k] = bsum[k];
               end else begin
                  for (int k = 0; k < 4; k++) begin
                     total = {1'b0, upper_pair[idx][k]} + {1'b0, bsum[k]};
                     avg[8*k +: 8] = total[9:2];
                  end
                  made = 1'b1;
               end
            end
         end
         col++;
         if (col >= w) begin
            col = 0;
            row++;
            if (row >= w) row = 0;
         end
         col_pos[lvl] = col;
         row_pos[lvl] = row;
         if (made) begin
            ent.mip_level   = LEVEL_W'(lvl + 1);
            ent.mip_pixel   = avg;
            ent.last_of_run = 1'b0;
            pending_mips.push_back(ent);
            n_out++;
            pix = avg;
         end else begin
            chain_on = 1'b0;
         end
      end
      if (n_out > 0) begin
         ent = pending_mips.pop_back();
         ent.last_of_run = 1'b1;
         pending_mips.push_back(ent);
      end
   endfunction

   function automatic logic [PIXEL_W-1:0] rand_pixel();
      logic [PIXEL_W-1:0] p;
      p = $urandom;
      // Now and then force every channel to a rail to hit the sum extremes.
      if ($urandom_range(7) == 0) begin
         for (int k = 0; k < 4; k++) p[8*k +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
      end
      return p;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Sends one base pixel; valid is left high so a following transaction
   // can go out back to back.
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.pixel_argb <= pix;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_mips(pix);
   endtask

   task automatic feed_pixels(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_pixel(rand_pixel());
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_mips.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.addr  <= addr;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      if (addr == CSR_SIZE_LOG2) begin
         cur_size = data;
         restart_chain();
      end else if (addr == CSR_LEVEL_COUNT) begin
         cur_levels = data;
         restart_chain();
      end
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] sz,
                            input logic [CSR_DATA_W-1:0] lv);
      wait_idle();
      write_reg(CSR_SIZE_LOG2, sz);
      write_reg(CSR_LEVEL_COUNT, lv);
   endtask

   // With the reset level count of zero nothing may come back.
   task automatic test_reset_state();
      wait_idle();
      send_pixel(32'h0000_0000);
      send_pixel(32'hffff_ffff);
      send_pixel(32'h8040_2010);
   endtask

   task automatic test_smallest_texture();
      configure(4'd1, 4'd1);
      send_pixel(32'h0000_0000);
      send_pixel(32'hffff_ffff);
      send_pixel(32'hffff_ffff);
      send_pixel(32'hffff_ffff);
      // Largest possible channel sums.
      repeat (4) send_pixel(32'hffff_ffff);
   endtask

   // Size 0 acts as 1 and a level count of 15 is cut down to it; the block
   // sum of 3 must truncate to 0.
   task automatic test_size_clamp();
      configure(4'd0, 4'd15);
      send_pixel(32'h0101_0101);
      send_pixel(32'h0101_0101);
      send_pixel(32'h0101_0101);
      send_pixel(32'h0000_0000);
   endtask

   task automatic test_level_cascade();
      configure(4'd2, 4'd2);
      feed_pixels(16);
   endtask

   // A write to an unused address keeps the position; a write to a real
   // register restarts the texture even with an unchanged value.
   task automatic test_restart();
      configure(4'd2, 4'd2);
      feed_pixels(5);
      wait_idle();
      write_reg(CSR_SPARE_ADDR, 4'hf);
      feed_pixels(11);
      feed_pixels(3);
      wait_idle();
      write_reg(CSR_LEVEL_COUNT, 4'd2);
      feed_pixels(16);
   endtask

   // An oversized exponent is cut to the largest size; the first row of
   // such a texture only advances the level positions.
   task automatic test_largest_size();
      configure(4'd15, 4'd10);
      feed_pixels(40);
   endtask

   task automatic test_random_textures(input int gap, input int stall);
      int unsigned useful, r, s_eff, full, count;
      logic [CSR_DATA_W-1:0] sz, lv;
      gap_pct   = gap;
      stall_pct = stall;
      useful    = 0;
      while (useful < ITEMS_PER_PHASE) begin
         r = $urandom_range(99);
         if (r < 30)      sz = 4'd1;
         else if (r < 60) sz = 4'd2;
         else if (r < 85) sz = 4'd3;
         else if (r < 92) sz = 4'd4;
         else             sz = CSR_DATA_W'($urandom_range(15));
         s_eff = clamped_size(sz);
         r = $urandom_range(99);
         if (r < 60)      lv = CSR_DATA_W'($urandom_range(s_eff, 1));
         else if (r < 88) lv = CSR_DATA_W'($urandom_range(15, s_eff));
         else             lv = 4'd0;
         if ($urandom_range(3) == 0) begin
            // Keep the size, change only the level count.
            wait_idle();
            write_reg(CSR_LEVEL_COUNT, lv);
         end else begin
            configure(sz, lv);
         end
         s_eff = clamped_size(cur_size);
         full  = 1 << (2 * s_eff);
         if (s_eff >= 5) begin
            count = $urandom_range(80, 8);
         end else begin
            r = $urandom_range(9);
            if (r == 0)      count = $urandom_range(full - 1, 1);
            else if (r == 1) count = full + $urandom_range(full, 1);
            else             count = full;
         end
         feed_pixels(count);
         if (active_levels() > 0) useful += count;
      end
   endtask

   always @(posedge clock) rsp_chan.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      rsp_entry_type exp_mip;
      if (rsp_chan.valid && rsp_chan.ready) begin
         if (pending_mips.size() == 0) begin
            report_mismatch($sformatf("unexpected result level %0d pixel %08h last %0b",
                                      rsp_chan.mip_level, rsp_chan.mip_pixel,
                                      rsp_chan.last_of_run));
         end else begin
            exp_mip = pending_mips.pop_front();
            if (rsp_chan.mip_level !== exp_mip.mip_level)
               report_mismatch($sformatf("mip_level %0d, expected %0d",
                                         rsp_chan.mip_level, exp_mip.mip_level));
            if (rsp_chan.mip_pixel !== exp_mip.mip_pixel)
               report_mismatch($sformatf("mip_pixel %08h, expected %08h (level %0d)",
                                         rsp_chan.mip_pixel, exp_mip.mip_pixel,
                                         exp_mip.mip_level));
            if (rsp_chan.last_of_run !== exp_mip.last_of_run)
               report_mismatch($sformatf("last_of_run %0b, expected %0b (level %0d)",
                                         rsp_chan.last_of_run, exp_mip.last_of_run,
                                         exp_mip.mip_level));
         end
      end
   end

   // Ends the run when no transaction of any kind completes for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.pixel_argb = '0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.addr       = '0;
      csr_chan.data       = '0;
      gap_pct             = 0;
      stall_pct           = 0;
      mismatch_count      = 0;
      quiet_cycles        = 0;
      cur_size            = SIZE_LOG2_RESET;
      cur_levels          = LEVEL_COUNT_RESET;
      restart_chain();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_smallest_texture();
      test_size_clamp();
      test_level_cascade();
      test_restart();
      test_largest_size();
      test_random_textures(0, 0);
      test_random_textures(70, 0);
      test_random_textures(0, 70);
      test_random_textures(32, 32);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
